[hw/rtl/pmc_pkg.sv]
package pmc_pkg;

	localparam logic [1:0] FUNC_COMPARE = 2'd0;
	localparam logic [1:0] FUNC_MARK    = 2'd1;
	localparam logic [1:0] FUNC_READOUT = 2'd2;

	localparam logic [7:0] BASE_A_UP = 8'h41;
	localparam logic [7:0] BASE_A_LO = 8'h61;
	localparam logic [7:0] BASE_C_UP = 8'h43;
	localparam logic [7:0] BASE_C_LO = 8'h63;
	localparam logic [7:0] BASE_G_UP = 8'h47;
	localparam logic [7:0] BASE_G_LO = 8'h67;
	localparam logic [7:0] BASE_T_UP = 8'h54;
	localparam logic [7:0] BASE_T_LO = 8'h74;

	// incoming request
	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] position;
		logic [7:0]  ref_base;
		logic [7:0]  read_base;
		logic        last_base;
	} cmd_t;

	// outgoing result
	typedef struct packed {
		logic [11:0] read_mismatches;
		logic [15:0] total_count;
		logic [15:0] a_count;
		logic [15:0] c_count;
		logic [15:0] g_count;
		logic [15:0] t_count;
		logic        snp_flag;
	} rsp_t;

endpackage

[hw/rtl/pileup_mismatch_counter_unit.sv]
// Per-position mismatch pileup. Takes one request per cycle while cmd_ready
// is high: the position's word (SNP bit and five counters) is read from a
// single-port-write memory at acceptance and the updated word is written back
// as the request leaves the stage register, with the written word forwarded to
// a request for the same position that follows directly. Results go through an
// output register, so cmd_ready only drops while a finished result is still
// waiting and the next request also has one. After reset a clearing pass
// zeroes all TRANSCRIPT_LEN entries, one a cycle, with cmd_ready low until done.
module pileup_mismatch_counter_unit
	import pmc_pkg::*;
#(
	parameter int TRANSCRIPT_LEN  = 65536,
	parameter int COUNT_BITS      = 16,
	parameter int READ_COUNT_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(TRANSCRIPT_LEN);
	localparam int PW = (AW > 16) ? AW + 1 : 17;
	localparam int CB = COUNT_BITS;
	localparam int MW = 1 + 5 * CB;
	localparam int OFS_TOT = 1;
	localparam int OFS_A   = 1 + CB;
	localparam int OFS_C   = 1 + 2 * CB;
	localparam int OFS_G   = 1 + 3 * CB;
	localparam int OFS_T   = 1 + 4 * CB;

	logic [MW-1:0] mem [TRANSCRIPT_LEN];

	logic                       clr_busy_q;
	logic [AW-1:0]              clr_addr_q;
	logic                       valid_s1;
	cmd_t                       cmd_s1;
	logic [AW-1:0]              idx_s1;
	logic                       in_range_s1;
	logic                       fwd_s1;
	logic [MW-1:0]              fwd_data_s1;
	logic [MW-1:0]              rd_s1;
	logic [READ_COUNT_BITS-1:0] running_q;
	logic                       rsp_valid_q;
	rsp_t                       rsp_q;

	logic [PW-1:0]              pos_ext;
	logic                       cmd_fire;
	logic [MW-1:0]              word;
	logic [MW-1:0]              new_word;
	logic                       mismatch;
	logic                       is_a, is_c, is_g, is_t;
	logic                       item_wr;
	logic                       has_rsp;
	logic                       s1_adv;
	logic [READ_COUNT_BITS-1:0] running_next;
	logic                       mem_wr;
	logic [AW-1:0]              mem_wr_idx;
	logic [MW-1:0]              mem_wr_data;
	rsp_t                       rsp_next;

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v, input logic en);
		sat_inc = (en && v != {CB{1'b1}}) ? v + CB'(1) : v;
	endfunction

	assign pos_ext = PW'(cmd.position);
	assign cmd_fire = cmd_valid && cmd_ready;

	assign word = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign mismatch = cmd_s1.ref_base != cmd_s1.read_base;
	assign is_a = cmd_s1.ref_base == BASE_A_UP || cmd_s1.ref_base == BASE_A_LO;
	assign is_c = cmd_s1.ref_base == BASE_C_UP || cmd_s1.ref_base == BASE_C_LO;
	assign is_g = cmd_s1.ref_base == BASE_G_UP || cmd_s1.ref_base == BASE_G_LO;
	assign is_t = cmd_s1.ref_base == BASE_T_UP || cmd_s1.ref_base == BASE_T_LO;

	always_comb begin
		logic cnt;
		cnt = cmd_s1.func == FUNC_COMPARE && mismatch && in_range_s1 && !word[0];
		new_word = word;
		if (cmd_s1.func == FUNC_MARK) begin
			new_word[0] = 1'b1;
		end
		new_word[OFS_TOT +: CB] = sat_inc(word[OFS_TOT +: CB], cnt);
		new_word[OFS_A +: CB]   = sat_inc(word[OFS_A +: CB], cnt && is_a);
		new_word[OFS_C +: CB]   = sat_inc(word[OFS_C +: CB], cnt && is_c);
		new_word[OFS_G +: CB]   = sat_inc(word[OFS_G +: CB], cnt && is_g);
		new_word[OFS_T +: CB]   = sat_inc(word[OFS_T +: CB], cnt && is_t);
		item_wr = in_range_s1 && !word[0] &&
			((cmd_s1.func == FUNC_COMPARE && mismatch) || cmd_s1.func == FUNC_MARK);
	end

	assign has_rsp = (cmd_s1.func == FUNC_COMPARE && cmd_s1.last_base) ||
		cmd_s1.func == FUNC_READOUT;
	assign s1_adv = valid_s1 && (!has_rsp || !rsp_valid_q || rsp_ready);
	assign cmd_ready = !clr_busy_q && (!valid_s1 || s1_adv);

	assign running_next = (mismatch && running_q != {READ_COUNT_BITS{1'b1}}) ?
		running_q + READ_COUNT_BITS'(1) : running_q;

	always_comb begin
		rsp_next = '0;
		if (cmd_s1.func == FUNC_COMPARE) begin
			rsp_next.read_mismatches = 12'(running_next);
		end else if (in_range_s1) begin
			rsp_next.total_count = 16'(word[OFS_TOT +: CB]);
			rsp_next.a_count     = 16'(word[OFS_A +: CB]);
			rsp_next.c_count     = 16'(word[OFS_C +: CB]);
			rsp_next.g_count     = 16'(word[OFS_G +: CB]);
			rsp_next.t_count     = 16'(word[OFS_T +: CB]);
			rsp_next.snp_flag    = word[0];
		end
	end

	// clearing pass owns the write port until it is done
	assign mem_wr      = clr_busy_q || (s1_adv && item_wr);
	assign mem_wr_idx  = clr_busy_q ? clr_addr_q : idx_s1;
	assign mem_wr_data = clr_busy_q ? '0 : new_word;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[mem_wr_idx] <= mem_wr_data;
		end
		if (cmd_fire) begin
			rd_s1 <= mem[pos_ext[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_s1      <= cmd;
			idx_s1      <= pos_ext[AW-1:0];
			in_range_s1 <= pos_ext < PW'(TRANSCRIPT_LEN);
			fwd_s1      <= s1_adv && item_wr && idx_s1 == pos_ext[AW-1:0];
			fwd_data_s1 <= new_word;
		end
		if (s1_adv && has_rsp) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			running_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(TRANSCRIPT_LEN - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cmd_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv && cmd_s1.func == FUNC_COMPARE) begin
				running_q <= cmd_s1.last_base ? '0 : running_next;
			end
			if (s1_adv && has_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !cmd_ready && !valid_s1)
		else $error("request taken during clearing pass");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && s1_adv && item_wr && idx_s1 == pos_ext[AW-1:0] |=> fwd_s1)
		else $error("back-to-back write to same entry not forwarded");

	a_held_result_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && has_rsp && rsp_valid_q && !rsp_ready |-> !cmd_ready)
		else $error("request taken while pending result blocked");

	a_read_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.read_mismatches != '0 |->
			rsp.total_count == '0 && !rsp.snp_flag)
		else $error("read result carries position counters");

endmodule

[tb/pileup_mismatch_counter_unit_tb.sv]
module pileup_mismatch_counter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pmc_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 300000;
	localparam logic [7:0] NUCLEOTIDES [8] = '{BASE_A_UP, BASE_A_LO, BASE_C_UP, BASE_C_LO,
		BASE_G_UP, BASE_G_LO, BASE_T_UP, BASE_T_LO};

	typedef struct packed {
		cmd_t c;
		logic typed;
		rsp_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 27;

	// want fields: read_mismatches, total, a, c, g, t, snp
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{'{FUNC_READOUT, 16'h0000, 8'h00, 8'h00, 1'b0}, 1'b1, '0},
		'{'{FUNC_READOUT, 16'hFFFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, '0},
		'{'{FUNC_COMPARE, 16'h0000, BASE_A_UP, BASE_C_UP, 1'b0}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'h0000, BASE_A_LO, BASE_A_UP, 1'b0}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'h0000, BASE_G_UP, BASE_G_UP, 1'b1}, 1'b1,
			'{12'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_READOUT, 16'h0000, 8'h00, 8'h00, 1'b0}, 1'b1,
			'{12'd0, 16'd2, 16'd2, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_COMPARE, 16'hFFFF, BASE_C_LO, BASE_G_LO, 1'b0}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'hFFFF, BASE_G_UP, BASE_G_LO, 1'b0}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'hFFFF, BASE_T_LO, BASE_T_UP, 1'b0}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'hFFFF, 8'hFF, 8'h00, 1'b0}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'hFFFF, 8'h00, 8'hFF, 1'b1}, 1'b1,
			'{12'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_READOUT, 16'hFFFF, 8'h00, 8'h00, 1'b0}, 1'b1,
			'{12'd0, 16'd5, 16'd0, 16'd1, 16'd1, 16'd1, 1'b0}},
		'{'{FUNC_MARK, 16'h1234, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
		'{'{FUNC_MARK, 16'h1234, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'h1234, BASE_A_UP, BASE_T_UP, 1'b1}, 1'b1,
			'{12'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_READOUT, 16'h1234, 8'h00, 8'h00, 1'b0}, 1'b1,
			'{12'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
		'{'{FUNC_UNUSED, 16'h0000, BASE_A_UP, BASE_C_UP, 1'b1}, 1'b0, '0},
		'{'{FUNC_READOUT, 16'h0000, 8'h00, 8'h00, 1'b0}, 1'b1,
			'{12'd0, 16'd2, 16'd2, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_COMPARE, 16'h0005, BASE_C_UP, BASE_A_UP, 1'b0}, 1'b0, '0},
		'{'{FUNC_READOUT, 16'h0005, 8'h00, 8'h00, 1'b0}, 1'b1,
			'{12'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_COMPARE, 16'h0006, BASE_T_UP, BASE_T_UP, 1'b1}, 1'b1,
			'{12'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_COMPARE, 16'h0005, BASE_C_LO, BASE_G_UP, 1'b0}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'h0005, BASE_C_LO, BASE_T_UP, 1'b1}, 1'b1,
			'{12'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_READOUT, 16'h0005, 8'h00, 8'h00, 1'b0}, 1'b1,
			'{12'd0, 16'd3, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_MARK, 16'hFFFF, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
		'{'{FUNC_COMPARE, 16'hFFFF, BASE_A_UP, BASE_C_UP, 1'b1}, 1'b1,
			'{12'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{FUNC_READOUT, 16'hFFFF, 8'h00, 8'h00, 1'b0}, 1'b1,
			'{12'd0, 16'd5, 16'd0, 16'd1, 16'd1, 16'd1, 1'b1}}
	};

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// typed expectation travels with the request it belongs to
	logic row_typed;
	rsp_t row_expect;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int fault_count = 0;
	int quiet_cycles = 0;

	// shadow of the pileup stores
	bit snp_marked [65536];
	bit [15:0] total_tally [65536];
	bit [15:0] a_tally [65536];
	bit [15:0] c_tally [65536];
	bit [15:0] g_tally [65536];
	bit [15:0] t_tally [65536];
	bit [11:0] read_tally;

	rsp_t pileup_results_q [$];

	pileup_mismatch_counter_unit dut (
		.clk,
		.arst_n,
		.cmd_valid,
		.cmd_ready,
		.cmd,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic bit [15:0] bump(input bit [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void apply_pileup(input cmd_t c, output logic has_rsp, output rsp_t r);
		logic [15:0] p;
		p = c.position;
		has_rsp = 1'b0;
		r = '0;
		case (c.func)
			FUNC_COMPARE: begin
				if (c.ref_base != c.read_base) begin
					if (read_tally != 12'hFFF)
						read_tally++;
					if (!snp_marked[p]) begin
						total_tally[p] = bump(total_tally[p]);
						case (c.ref_base)
							BASE_A_UP, BASE_A_LO: a_tally[p] = bump(a_tally[p]);
							BASE_C_UP, BASE_C_LO: c_tally[p] = bump(c_tally[p]);
							BASE_G_UP, BASE_G_LO: g_tally[p] = bump(g_tally[p]);
							BASE_T_UP, BASE_T_LO: t_tally[p] = bump(t_tally[p]);
							default: ;
						endcase
					end
				end
				if (c.last_base) begin
					has_rsp = 1'b1;
					r.read_mismatches = read_tally;
					read_tally = '0;
				end
			end
			FUNC_MARK: snp_marked[p] = 1'b1;
			FUNC_READOUT: begin
				has_rsp = 1'b1;
				r.total_count = total_tally[p];
				r.a_count = a_tally[p];
				r.c_count = c_tally[p];
				r.g_count = g_tally[p];
				r.t_count = t_tally[p];
				r.snp_flag = snp_marked[p];
			end
			default: ;
		endcase
	endfunction

	task automatic log_fault(input string msg);
		$display("%0t ns: %s", $time, msg);
		fault_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			log_fault($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin : score
		rsp_t want;
		logic has_rsp;
		if (rsp_valid && rsp_ready) begin
			if (pileup_results_q.size() == 0) begin
				log_fault("result with no request outstanding");
			end else begin
				want = pileup_results_q.pop_front();
				check_field("read_mismatches", 16'(rsp.read_mismatches),
					16'(want.read_mismatches));
				check_field("total_count", rsp.total_count, want.total_count);
				check_field("a_count", rsp.a_count, want.a_count);
				check_field("c_count", rsp.c_count, want.c_count);
				check_field("g_count", rsp.g_count, want.g_count);
				check_field("t_count", rsp.t_count, want.t_count);
				check_field("snp_flag", 16'(rsp.snp_flag), 16'(want.snp_flag));
			end
		end
		if (cmd_valid && cmd_ready) begin
			apply_pileup(cmd, has_rsp, want);
			if (has_rsp) begin
				if (row_typed)
					want = row_expect;
				pileup_results_q = {pileup_results_q, want};
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				// long hold-off so the block backs up into its input
				n = hold_len;
				hold_len = 0;
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_request(input cmd_t c, input logic typed, input rsp_t want);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		row_typed <= typed;
		row_expect <= want;
		do @(posedge clk); while (cmd_ready !== 1'b1);
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pileup_results_q.size() != 0);
	endtask

	function automatic logic [7:0] pick_base();
		if ($urandom_range(99) < 85)
			return NUCLEOTIDES[$urandom_range(7)];
		return 8'($urandom_range(255));
	endfunction

	// hot windows at both ends so counts pile up, the rest spread wide
	function automatic logic [15:0] pick_pos();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return 16'($urandom_range(31));
		if (roll < 60)
			return 16'hFFE0 + 16'($urandom_range(31));
		return 16'($urandom_range(16'hFFFF));
	endfunction

	task automatic run_reads(input int quota);
		int sent;
		int len;
		int roll;
		cmd_t c;
		cmd_t peek;
		sent = 0;
		while (sent < quota) begin
			roll = $urandom_range(99);
			c.position = pick_pos();
			c.ref_base = 8'($urandom_range(255));
			c.read_base = 8'($urandom_range(255));
			c.last_base = 1'($urandom_range(1));
			if (roll < 70) begin
				len = $urandom_range(1, 24);
				for (int k = 0; k < len; k++) begin
					// readout in the middle of a read, often right behind an update
					if ($urandom_range(19) == 0) begin
						peek = c;
						peek.func = FUNC_READOUT;
						send_request(peek, 1'b0, '0);
						sent++;
					end
					c.func = FUNC_COMPARE;
					c.ref_base = pick_base();
					c.read_base = ($urandom_range(99) < 35) ? pick_base() : c.ref_base;
					c.last_base = (k == len - 1);
					send_request(c, 1'b0, '0);
					sent++;
					if ($urandom_range(3) != 0)
						c.position++;
				end
			end else begin
				if (roll < 82)
					c.func = FUNC_MARK;
				else if (roll < 97)
					c.func = FUNC_READOUT;
				else
					c.func = FUNC_UNUSED;
				send_request(c, 1'b0, '0);
				if (c.func != FUNC_UNUSED)
					sent++;
			end
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		row_typed <= 1'b0;
		row_expect <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		hold_len = 300;
		run_reads(380);
		drain_results();

		idle_pct = 82;
		run_reads(380);
		drain_results();

		idle_pct = 0;
		stall_pct = 82;
		run_reads(380);
		drain_results();

		idle_pct = 35;
		stall_pct = 35;
		run_reads(380);
		drain_results();

		repeat (16) @(posedge clk);
		if (fault_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
